[rtl/core/cle_pkg.sv]
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types, character codes and status codes of the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

   // line store geometry
   localparam int LINE_DEPTH = 128;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ETX   = 8'h03;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_C     = 8'h43;

   // operation codes
   localparam logic OP_RX   = 1'b0;
   localparam logic OP_READ = 1'b1;

   // line status codes
   localparam logic [2:0] ST_RUN    = 3'd0;
   localparam logic [2:0] ST_DONE   = 3'd1;
   localparam logic [2:0] ST_CANCEL = 3'd2;
   localparam logic [2:0] ST_ABORT  = 3'd3;
   localparam logic [2:0] ST_OVFL   = 3'd4;

   // capacity after reset
   localparam logic [6:0] CAP_RESET = 7'd99;

   // what an accepted transaction turns into on the result side
   typedef enum logic [2:0] {
      K_READ,
      K_NUL,
      K_EOL,
      K_BS,
      K_BS_EMPTY,
      K_ETX,
      K_CHAR
   } kind_type;

   // descriptor handed from the decoder to the echo sequencer
   typedef struct packed {
      kind_type   kind;
      logic [7:0] rx_byte;
      logic [2:0] status;
      logic [6:0] length;
      logic       rd_ok;
   } job_type;

   // position lies inside the line store
   function automatic logic pos_ok(logic [6:0] pos);
      return 32'(pos) < 32'(LINE_DEPTH);
   endfunction

endpackage

[rtl/core/cle_echo_seq.sv]
// ----------------------------------------------------------------------------
// cle_echo_seq
// Holds one decoded transaction and plays out its result items, one per
// cycle while rsp_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module cle_echo_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_load,
   input  cle_pkg::job_type job,
   input  logic [7:0]       rd_data,
   output logic             job_free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_echo_byte,
   output logic             rsp_echo_valid,
   output logic             rsp_last,
   output logic [2:0]       rsp_status,
   output logic [6:0]       rsp_line_length,
   output logic [7:0]       rsp_read_data
);

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } echo_type;

   // index of the final result of a transaction
   function automatic logic [1:0] last_idx(cle_pkg::kind_type k);
      case (k)
         cle_pkg::K_EOL: return 2'd1;
         cle_pkg::K_BS:  return 2'd2;
         cle_pkg::K_ETX: return 2'd3;
         default:        return 2'd0;
      endcase
   endfunction

   // echo character of result number idx
   function automatic echo_type echo_of(cle_pkg::kind_type k, logic [1:0] idx,
                                        logic [7:0] b);
      echo_type e;
      e.valid = 1'b1;
      e.data  = 8'h00;
      case (k)
         cle_pkg::K_EOL:  e.data = (idx == 2'd0) ? cle_pkg::CH_CR : cle_pkg::CH_LF;
         cle_pkg::K_BS:   e.data = (idx == 2'd1) ? cle_pkg::CH_SPACE : cle_pkg::CH_BS;
         cle_pkg::K_ETX: begin
            case (idx)
               2'd0:    e.data = cle_pkg::CH_CARET;
               2'd1:    e.data = cle_pkg::CH_C;
               2'd2:    e.data = cle_pkg::CH_CR;
               default: e.data = cle_pkg::CH_LF;
            endcase
         end
         cle_pkg::K_CHAR: e.data = b;
         default:         e.valid = 1'b0;
      endcase
      return e;
   endfunction

   cle_pkg::job_type job_ff;
   logic             job_valid_ff;
   logic [1:0]       idx_ff, idx_in;
   logic             rsp_valid_ff;
   logic [7:0]       echo_byte_ff;
   logic             echo_valid_ff;
   logic             last_ff;
   logic [2:0]       status_ff;
   logic [6:0]       length_ff;
   logic [7:0]       read_data_ff;

   logic     load_out;
   logic     is_last;
   echo_type cur_echo;

   // output stage takes the next result when empty or being drained
   assign load_out = job_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign is_last  = (idx_ff == last_idx(job_ff.kind));
   assign job_free = !job_valid_ff || (load_out && is_last);
   assign cur_echo = echo_of(job_ff.kind, idx_ff, job_ff.rx_byte);

   // result counter
   always_comb begin
      idx_in = idx_ff;
      if (job_free) begin
         idx_in = 2'd0;
      end else if (load_out) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   // job slot and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         if (job_free) begin
            job_valid_ff <= job_load;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_free && job_load) begin
         job_ff <= job;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         echo_valid_ff <= cur_echo.valid;
         echo_byte_ff  <= cur_echo.valid ? cur_echo.data : 8'h00;
         last_ff       <= is_last;
         status_ff     <= is_last ? job_ff.status : cle_pkg::ST_RUN;
         length_ff     <= is_last ? job_ff.length : 7'd0;
         read_data_ff  <= (job_ff.kind == cle_pkg::K_READ && job_ff.rd_ok) ?
                          rd_data : 8'h00;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_echo_byte   = echo_byte_ff;
   assign rsp_echo_valid  = echo_valid_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;
   assign rsp_line_length = length_ff;
   assign rsp_read_data   = read_data_ff;

endmodule

[rtl/core/console_line_editor.sv]
// ----------------------------------------------------------------------------
// console_line_editor
// Console line assembly with echo generation and a readable line store.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per received byte (op 0) or per line store
//            read (op 1, read_index selects the position).
//   rsp_*  : one to four result transactions per request, the last one
//            flagged by rsp_last and carrying status and line length.
//   csr_*  : write of line_capacity, always ready; write only while idle.
// Requests go to the job slot, their results through the output register.
// Results: one item per cycle while rsp_stall is low; one item for a
//   plain character, read, NUL or empty backspace, 2 for CR/LF, 3 for
//   backspace, 4 for Ctrl-C; an overflowing character also holds off the
//   next request while the single write port stores the terminator.
// The next request is taken in the cycle the previous one hands over its
//   last result to the output register, unless a terminator write pends.
// Reset clears the character count, sets line_capacity to 99 and empties
//   the pipeline; the line store content is not cleared.
// While rsp_stall is high the output register holds and req_stall rises
//   once the pending transaction has no room left.
// ----------------------------------------------------------------------------
module console_line_editor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_rx_byte,
   input  logic [6:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_echo_byte,
   output logic       rsp_echo_valid,
   output logic       rsp_last,
   output logic [2:0] rsp_status,
   output logic [6:0] rsp_line_length,
   output logic [7:0] rsp_read_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_data
);

   logic [7:0] line_mem [cle_pkg::LINE_DEPTH];
   logic [7:0] mem_rd_ff;

   logic [6:0] count_ff, count_in;
   logic [6:0] cap_ff;
   logic       pend_ff;
   logic [6:0] pend_pos_ff;

   cle_pkg::job_type dec_job;
   logic             dec_wr;
   logic [6:0]       dec_wr_pos;
   logic [7:0]       dec_wr_data;
   logic             dec_pend;
   logic [6:0]       dec_pend_pos;
   logic [6:0]       cnt_inc;

   logic job_free;
   logic accept;

   // request handshake, held off while the sequencer is busy or the terminator write is pending
   assign req_stall = !job_free || pend_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign cnt_inc   = count_ff + 7'd1;

   // decode of one request against the current line
   always_comb begin
      dec_job.kind    = cle_pkg::K_READ;
      dec_job.rx_byte = req_rx_byte;
      dec_job.status  = cle_pkg::ST_RUN;
      dec_job.length  = 7'd0;
      dec_job.rd_ok   = cle_pkg::pos_ok(req_read_index);
      dec_wr          = 1'b0;
      dec_wr_pos      = count_ff;
      dec_wr_data     = 8'h00;
      dec_pend        = 1'b0;
      dec_pend_pos    = cnt_inc;
      count_in        = count_ff;
      if (req_op == cle_pkg::OP_RX) begin
         case (req_rx_byte)
            cle_pkg::CH_NUL: begin
               dec_job.kind   = cle_pkg::K_NUL;
               dec_job.status = cle_pkg::ST_ABORT;
               count_in       = 7'd0;
            end
            cle_pkg::CH_CR, cle_pkg::CH_LF: begin
               dec_job.kind   = cle_pkg::K_EOL;
               dec_job.status = cle_pkg::ST_DONE;
               dec_job.length = count_ff;
               dec_wr         = 1'b1;
               count_in       = 7'd0;
            end
            cle_pkg::CH_BS: begin
               if (count_ff != 7'd0) begin
                  dec_job.kind = cle_pkg::K_BS;
                  count_in     = count_ff - 7'd1;
               end else begin
                  dec_job.kind = cle_pkg::K_BS_EMPTY;
               end
            end
            cle_pkg::CH_ETX: begin
               dec_job.kind   = cle_pkg::K_ETX;
               dec_job.status = cle_pkg::ST_CANCEL;
               dec_wr         = 1'b1;
               dec_wr_pos     = 7'd0;
               count_in       = 7'd0;
            end
            default: begin
               dec_job.kind = cle_pkg::K_CHAR;
               dec_wr       = 1'b1;
               dec_wr_data  = req_rx_byte;
               if (cnt_inc == 7'd0 || cnt_inc >= cap_ff) begin
                  dec_job.status = cle_pkg::ST_OVFL;
                  dec_pend       = 1'b1;
                  count_in       = 7'd0;
               end else begin
                  count_in = cnt_inc;
               end
            end
         endcase
      end
   end

   // line state and capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd0;
         cap_ff   <= cle_pkg::CAP_RESET;
         pend_ff  <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         pend_ff <= accept && dec_pend && cle_pkg::pos_ok(dec_pend_pos);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_pos_ff <= dec_pend_pos;
      end
   end

   // line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         line_mem[cle_pkg::ADDR_W'(pend_pos_ff)] <= 8'h00;
      end else if (accept && dec_wr && cle_pkg::pos_ok(dec_wr_pos)) begin
         line_mem[cle_pkg::ADDR_W'(dec_wr_pos)] <= dec_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_op == cle_pkg::OP_READ && cle_pkg::pos_ok(req_read_index)) begin
         mem_rd_ff <= line_mem[cle_pkg::ADDR_W'(req_read_index)];
      end
   end

   // echo and result sequencing
   cle_echo_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .job_load        (accept),
      .job             (dec_job),
      .rd_data         (mem_rd_ff),
      .job_free        (job_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_line_length (rsp_line_length),
      .rsp_read_data   (rsp_read_data)
   );

`ifndef ASSERT_OFF
   // no request slips past a pending terminator write
   a_pend_blocks: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> req_stall)
      else $error("request accepted during pending store write");

   // terminator write occupies a single cycle
   a_pend_single: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff)
      else $error("pending store write held over");

   // status only on the final result of a transaction
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != cle_pkg::ST_RUN) |-> rsp_last)
      else $error("status reported before last result");

   // silent results carry no echo character
   a_echo_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_echo_valid) |-> (rsp_echo_byte == 8'h00))
      else $error("echo byte set without echo valid");
`endif

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the console line editor. A short scripted sequence
// covers empty backspace, NUL abort, extreme bytes, end of line, Ctrl-C and
// store reads. Random keystroke streams then run at several line capacities,
// including a lowered capacity in mid line, zero, one and the maximum of 127.
// Every result transaction is checked field by field against an in-bench
// model of the line discipline, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int SCRIPT_LEN     = 21;

   // one result transaction as seen on the rsp_ port
   typedef struct packed {
      logic [7:0] echo_byte;
      logic       echo_valid;
      logic       last;
      logic [2:0] status;
      logic [6:0] line_length;
      logic [7:0] read_data;
   } echo_beat_type;

   // one scripted keystroke; pinned rows carry the status and length of the
   // final result transaction
   typedef struct packed {
      logic       op;
      logic [7:0] rx;
      logic [6:0] idx;
      logic       pinned;
      logic [2:0] status;
      logic [6:0] length;
   } key_row_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic       req_op         = cle_pkg::OP_RX;
   logic [7:0] req_rx_byte    = 8'h00;
   logic [6:0] req_read_index = 7'd0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_echo_byte;
   logic       rsp_echo_valid;
   logic       rsp_last;
   logic [2:0] rsp_status;
   logic [6:0] rsp_line_length;
   logic [7:0] rsp_read_data;
   logic       csr_valid      = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data       = 7'd0;

   // model state of the line discipline
   logic [7:0] line_mem [cle_pkg::LINE_DEPTH];
   bit         line_written [cle_pkg::LINE_DEPTH];
   logic [6:0] char_cnt = 7'd0;
   logic [6:0] line_cap = cle_pkg::CAP_RESET;

   echo_beat_type echo_due [$];

   // run control shared between the stimulus and the receiver
   bit calm         = 1'b0;
   int hold_request = 0;

   // bookkeeping
   int faults       = 0;
   int keys_sent    = 0;
   int reads_sent   = 0;
   int beats_seen   = 0;
   int cap_writes   = 0;
   int lines_done   = 0;
   int lines_cancel = 0;
   int lines_abort  = 0;
   int lines_ovfl   = 0;
   int quiet_cycles = 0;

   // first row: backspace on empty line; last row leaves the line open
   key_row_type script [SCRIPT_LEN] = '{
      '{cle_pkg::OP_RX,   cle_pkg::CH_BS,  7'd0, 1'b1, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   cle_pkg::CH_NUL, 7'd0, 1'b1, cle_pkg::ST_ABORT,  7'd0},
      '{cle_pkg::OP_RX,   8'h61,           7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   8'hFF,           7'd0, 1'b1, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   8'h01,           7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   8'h80,           7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   8'h7F,           7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   cle_pkg::CH_BS,  7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   cle_pkg::CH_CR,  7'd0, 1'b1, cle_pkg::ST_DONE,   7'd4},
      '{cle_pkg::OP_READ, 8'h00,           7'd0, 1'b1, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_READ, 8'hFF,           7'd1, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_READ, 8'h00,           7'd4, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   8'h78,           7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   8'h79,           7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   cle_pkg::CH_ETX, 7'd0, 1'b1, cle_pkg::ST_CANCEL, 7'd0},
      '{cle_pkg::OP_READ, 8'h00,           7'd0, 1'b1, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   8'h7A,           7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   cle_pkg::CH_LF,  7'd0, 1'b1, cle_pkg::ST_DONE,   7'd1},
      '{cle_pkg::OP_READ, 8'h00,           7'd1, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   8'h71,           7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0},
      '{cle_pkg::OP_RX,   8'h72,           7'd0, 1'b0, cle_pkg::ST_RUN,    7'd0}
   };

   console_line_editor DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_rx_byte     (req_rx_byte),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_line_length (rsp_line_length),
      .rsp_read_data   (rsp_read_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // result transaction carrying one echoed character
   function automatic echo_beat_type echo_of(logic [7:0] ch);
      echo_beat_type b;
      b = '0;
      b.echo_byte  = ch;
      b.echo_valid = 1'b1;
      return b;
   endfunction

   // line store write, remembering which entries hold data
   function automatic void keep_byte(logic [6:0] pos, logic [7:0] v);
      line_mem[pos]     = v;
      line_written[pos] = 1'b1;
   endfunction

   // line discipline: advance the model and queue the results of one transaction
   function automatic void predict_echo(logic op, logic [7:0] rx, logic [6:0] idx,
                                        logic pinned, logic [2:0] pin_status,
                                        logic [6:0] pin_length);
      echo_beat_type beat [4];
      int n;
      n = 0;
      for (int k = 0; k < 4; k++) beat[k] = '0;
      if (op == cle_pkg::OP_READ) begin
         beat[0].read_data = line_mem[idx];
         n = 1;
      end else if (rx == cle_pkg::CH_NUL) begin
         beat[0].status = cle_pkg::ST_ABORT;
         char_cnt = 7'd0;
         n = 1;
         lines_abort++;
      end else if (rx == cle_pkg::CH_CR || rx == cle_pkg::CH_LF) begin
         beat[0] = echo_of(cle_pkg::CH_CR);
         beat[1] = echo_of(cle_pkg::CH_LF);
         beat[1].status      = cle_pkg::ST_DONE;
         beat[1].line_length = char_cnt;
         keep_byte(char_cnt, 8'h00);
         char_cnt = 7'd0;
         n = 2;
         lines_done++;
      end else if (rx == cle_pkg::CH_BS) begin
         if (char_cnt != 7'd0) begin
            char_cnt = char_cnt - 7'd1;
            beat[0] = echo_of(cle_pkg::CH_BS);
            beat[1] = echo_of(cle_pkg::CH_SPACE);
            beat[2] = echo_of(cle_pkg::CH_BS);
            n = 3;
         end else begin
            n = 1;
         end
      end else if (rx == cle_pkg::CH_ETX) begin
         beat[0] = echo_of(cle_pkg::CH_CARET);
         beat[1] = echo_of(cle_pkg::CH_C);
         beat[2] = echo_of(cle_pkg::CH_CR);
         beat[3] = echo_of(cle_pkg::CH_LF);
         beat[3].status = cle_pkg::ST_CANCEL;
         keep_byte(7'd0, 8'h00);
         char_cnt = 7'd0;
         n = 4;
         lines_cancel++;
      end else begin
         // plain character, overflow when the count reaches capacity
         keep_byte(char_cnt, rx);
         beat[0] = echo_of(rx);
         char_cnt = char_cnt + 7'd1;
         n = 1;
         if (char_cnt == 7'd0 || char_cnt >= line_cap) begin
            keep_byte(char_cnt, 8'h00);
            char_cnt = 7'd0;
            beat[0].status = cle_pkg::ST_OVFL;
            lines_ovfl++;
         end
      end
      beat[n-1].last = 1'b1;
      if (pinned) begin
         beat[n-1].status      = pin_status;
         beat[n-1].line_length = pin_length;
      end
      for (int k = 0; k < n; k++) echo_due.push_back(beat[k]);
   endfunction

   // offer one request transaction, starting and ending at a falling edge
   task automatic offer_key(logic op, logic [7:0] rx, logic [6:0] idx,
                            logic pinned, logic [2:0] pin_status, logic [6:0] pin_length);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_rx_byte    <= rx;
      req_read_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_echo(op, rx, idx, pinned, pin_status, pin_length);
      keys_sent++;
      if (op == cle_pkg::OP_READ) reads_sent++;
      @(negedge clock);
   endtask

   // random keystroke, weights in percent; the rest read a written entry if any
   task automatic offer_random_key(int w_char, int w_eol, int w_bs, int w_etx, int w_nul);
      int pick;
      int start;
      int slot;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      slot = -1;
      if (pick >= w_char + w_eol + w_bs + w_etx + w_nul) begin
         start = $urandom_range(0, cle_pkg::LINE_DEPTH - 1);
         for (int k = 0; k < cle_pkg::LINE_DEPTH && slot < 0; k++)
            if (line_written[(start + k) % cle_pkg::LINE_DEPTH])
               slot = (start + k) % cle_pkg::LINE_DEPTH;
      end
      if (slot >= 0) begin
         offer_key(cle_pkg::OP_READ, 8'($urandom), 7'(slot), 1'b0, cle_pkg::ST_RUN, 7'd0);
      end else if (pick >= w_char && pick < w_char + w_eol) begin
         offer_key(cle_pkg::OP_RX,
                   $urandom_range(0, 1) ? cle_pkg::CH_CR : cle_pkg::CH_LF,
                   7'($urandom), 1'b0, cle_pkg::ST_RUN, 7'd0);
      end else if (pick >= w_char + w_eol && pick < w_char + w_eol + w_bs) begin
         offer_key(cle_pkg::OP_RX, cle_pkg::CH_BS, 7'($urandom), 1'b0, cle_pkg::ST_RUN, 7'd0);
      end else if (pick >= w_char + w_eol + w_bs && pick < w_char + w_eol + w_bs + w_etx) begin
         offer_key(cle_pkg::OP_RX, cle_pkg::CH_ETX, 7'($urandom), 1'b0, cle_pkg::ST_RUN,
                   7'd0);
      end else if (pick >= w_char + w_eol + w_bs + w_etx &&
                   pick < w_char + w_eol + w_bs + w_etx + w_nul) begin
         offer_key(cle_pkg::OP_RX, cle_pkg::CH_NUL, 7'($urandom), 1'b0, cle_pkg::ST_RUN,
                   7'd0);
      end else begin
         do b = 8'($urandom_range(1, 255));
         while (b == cle_pkg::CH_ETX || b == cle_pkg::CH_BS ||
                b == cle_pkg::CH_LF || b == cle_pkg::CH_CR);
         offer_key(cle_pkg::OP_RX, b, 7'($urandom), 1'b0, cle_pkg::ST_RUN, 7'd0);
      end
   endtask

   // stop offering and wait for every expected result plus the terminator write
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (echo_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // capacity register write, only with the editor idle
   task automatic set_capacity(logic [6:0] cap);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      line_cap = cap;
      cap_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall bursts, plus a long hold-off on request
   initial begin : rsp_side
      int burst_left;
      int hold_left;
      burst_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left != 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(1, 7) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker: each result transaction against the oldest expectation
   always @(posedge clock) begin : check_beats
      echo_beat_type got;
      echo_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_echo_byte, rsp_echo_valid, rsp_last, rsp_status,
                 rsp_line_length, rsp_read_data};
         beats_seen++;
         if (echo_due.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("unexpected result: echo %h/%b last %b status %0d len %0d data %h",
                        got.echo_byte, got.echo_valid, got.last, got.status,
                        got.line_length, got.read_data);
         end else begin
            want = echo_due.pop_front();
            if (got.echo_byte !== want.echo_byte || got.echo_valid !== want.echo_valid ||
                got.last !== want.last || got.status !== want.status ||
                got.line_length !== want.line_length || got.read_data !== want.read_data) begin
               faults++;
               if (faults <= REPORT_LIMIT) begin
                  $display("result %0d exp: echo %h/%b last %b status %0d len %0d data %h",
                           beats_seen, want.echo_byte, want.echo_valid, want.last,
                           want.status, want.line_length, want.read_data);
                  $display("result %0d got: echo %h/%b last %b status %0d len %0d data %h",
                           beats_seen, got.echo_byte, got.echo_valid, got.last,
                           got.status, got.line_length, got.read_data);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on any port
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d results outstanding",
                  quiet_cycles, echo_due.size());
         $display("console_line_editor: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // main sequence
   initial begin : stimulus
      int ovfl_mark;
      int n;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // scripted keystrokes at the reset capacity
      for (int i = 0; i < SCRIPT_LEN; i++)
         offer_key(script[i].op, script[i].rx, script[i].idx, script[i].pinned,
                   script[i].status, script[i].length);

      // capacity lowered below the open line: next character overflows
      set_capacity(7'd2);
      offer_key(cle_pkg::OP_RX, 8'h73, 7'd0, 1'b1, cle_pkg::ST_OVFL, 7'd0);
      repeat (4) offer_random_key(60, 10, 12, 5, 5);

      // zero capacity: every character overflows
      set_capacity(7'd0);
      repeat (4) offer_random_key(60, 10, 10, 5, 5);

      // full capacity: one long line up to overflow, then reads across the store
      set_capacity(7'd127);
      ovfl_mark = lines_ovfl;
      n = 0;
      while (lines_ovfl == ovfl_mark) begin
         if (n == 70) calm = 1'b1;
         offer_random_key(96, 0, 1, 0, 0);
         n++;
      end
      repeat (6) offer_random_key(0, 0, 0, 0, 0);
      calm = 1'b0;

      // mid capacity with a long receiver hold-off and a full drain
      set_capacity(7'($urandom_range(3, 126)));
      for (int i = 0; i < 20; i++) begin
         if (i == 6) hold_request = 64;
         if (i == 13) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (echo_due.size() != 0) @(negedge clock);
         end
         offer_random_key(55, 10, 10, 4, 3);
      end

      // capacity one
      set_capacity(7'd1);
      repeat (4) offer_random_key(60, 10, 10, 5, 5);

      // closing stretch with no idling
      set_capacity(7'd5);
      calm = 1'b1;
      repeat (10) offer_random_key(60, 10, 10, 5, 5);

      settle();
      repeat (8) @(posedge clock);
      $display("ran %0d transactions (%0d reads) at %0d capacity settings, %0d results checked",
               keys_sent, reads_sent, cap_writes + 1, beats_seen);
      $display("lines: %0d complete, %0d cancelled, %0d aborted, %0d overflowed",
               lines_done, lines_cancel, lines_abort, lines_ovfl);
      if (faults == 0 && echo_due.size() == 0) begin
         $display("console_line_editor: match");
      end else begin
         $display("%0d faults, %0d results never arrived", faults, echo_due.size());
         $display("console_line_editor: mismatch");
      end
      $finish;
   end

endmodule
